// File: sv/lncp_pkg.sv
package lncp_pkg;

	localparam int COORD_W = 32;
	localparam int CFG_W   = 32;
	localparam int DEPTH_W = 31;
	localparam int MAG_W   = ((COORD_W > 32) ? COORD_W : 32) + 1;
	localparam int SGN_W   = MAG_W + 1;
	localparam int QUO_W   = MAG_W + 1;
	localparam int PRD_W   = 2 * MAG_W;

	typedef enum logic [1:0] {
		CFG_NEAR_DEPTH   = 2'd0,
		CFG_FOCAL_LENGTH = 2'd1,
		CFG_CENTER_X     = 2'd2,
		CFG_CENTER_Y     = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] start_z;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
		logic signed [COORD_W-1:0] end_z;
	} seg_in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] screen_start_x;
		logic signed [COORD_W-1:0] screen_start_y;
		logic signed [COORD_W-1:0] screen_end_x;
		logic signed [COORD_W-1:0] screen_end_y;
	} seg_out_t;

	typedef struct packed {
		logic [MAG_W-1:0] rem;
		logic [QUO_W-1:0] num;
		logic [QUO_W-1:0] quo;
		logic [MAG_W-1:0] den;
		logic             neg;
		logic             ov;
	} div_lane_t;

	typedef struct packed {
		seg_in_t            seg;
		logic               clip_start;
		logic               clip_end;
		logic [DEPTH_W-1:0] near;
	} clip_side_t;

endpackage

// File: sv/lncp_div_cell.sv
module lncp_div_cell (
	input  logic                clk,
	input  logic                en,
	input  lncp_pkg::div_lane_t lane_i,
	output lncp_pkg::div_lane_t lane_o
);
	import lncp_pkg::*;

	logic [MAG_W:0] trial;
	logic           fits;
	div_lane_t      nxt;

	always_comb begin
		trial = {lane_i.rem, lane_i.num[QUO_W-1]};
		fits  = trial >= {1'b0, lane_i.den};
		nxt   = lane_i;
		nxt.rem = fits ? MAG_W'(trial - {1'b0, lane_i.den}) : MAG_W'(trial);
		nxt.num = {lane_i.num[QUO_W-2:0], 1'b0};
		nxt.quo = {lane_i.quo[QUO_W-2:0], fits};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_o <= nxt;
		end
	end

endmodule

// File: sv/lncp_muldiv.sv
module lncp_muldiv #(
	parameter int LANES  = 2,
	parameter int SIDE_W = 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              valid_i,
	input  logic signed [lncp_pkg::SGN_W-1:0] a_i [LANES],
	input  logic signed [lncp_pkg::SGN_W-1:0] b_i [LANES],
	input  logic signed [lncp_pkg::SGN_W-1:0] d_i [LANES],
	input  logic        [SIDE_W-1:0]          side_i,
	output logic                              valid_o,
	output logic signed [lncp_pkg::QUO_W:0]   q_o [LANES],
	output logic        [SIDE_W-1:0]          side_o
);
	import lncp_pkg::*;

	function automatic logic [MAG_W-1:0] mag(input logic signed [SGN_W-1:0] v);
		return v[SGN_W-1] ? MAG_W'(-v) : MAG_W'(v);
	endfunction

	logic                v_s1;
	logic [SIDE_W-1:0]   side_s1;
	logic [PRD_W-1:0]    prod_s1 [LANES];
	logic [MAG_W-1:0]    den_s1  [LANES];
	logic                neg_s1  [LANES];

	logic                v_q    [QUO_W+1];
	logic [SIDE_W-1:0]   side_q [QUO_W+1];
	div_lane_t           st_q   [LANES][QUO_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int k = 0; k <= QUO_W; k++) v_q[k] <= 1'b0;
			valid_o <= 1'b0;
		end else if (en) begin
			v_s1   <= valid_i;
			v_q[0] <= v_s1;
			for (int k = 0; k < QUO_W; k++) v_q[k+1] <= v_q[k];
			valid_o <= v_q[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1   <= side_i;
			side_q[0] <= side_s1;
			for (int k = 0; k < QUO_W; k++) side_q[k+1] <= side_q[k];
			side_o <= side_q[QUO_W];
			for (int l = 0; l < LANES; l++) begin
				prod_s1[l] <= PRD_W'(mag(a_i[l])) * PRD_W'(mag(b_i[l]));
				den_s1[l]  <= mag(d_i[l]);
				neg_s1[l]  <= a_i[l][SGN_W-1] ^ b_i[l][SGN_W-1] ^ d_i[l][SGN_W-1];
			end
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		logic [QUO_W-1:0] qmag;

		always_ff @(posedge clk) begin
			if (en) begin
				st_q[l][0].rem <= {1'b0, prod_s1[l][PRD_W-1:QUO_W]};
				st_q[l][0].num <= prod_s1[l][QUO_W-1:0];
				st_q[l][0].quo <= '0;
				st_q[l][0].den <= den_s1[l];
				st_q[l][0].neg <= neg_s1[l];
				st_q[l][0].ov  <= {1'b0, prod_s1[l][PRD_W-1:QUO_W]} >= den_s1[l];
			end
		end

		for (genvar k = 0; k < QUO_W; k++) begin : g_cell
			lncp_div_cell u_cell (
				.clk    (clk),
				.en     (en),
				.lane_i (st_q[l][k]),
				.lane_o (st_q[l][k+1])
			);
		end

		assign qmag = st_q[l][QUO_W].ov ? '1 : st_q[l][QUO_W].quo;

		always_ff @(posedge clk) begin
			if (en) begin
				q_o[l] <= st_q[l][QUO_W].neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
			end
		end
	end

endmodule

// File: sv/line_near_clip_project.sv
// channel | signals                        | word
// in      | in_valid, in_stall, in_data    | seg_in_t, one 3D segment
// out     | out_valid, out_stall, out_data | seg_out_t, one 2D segment
// cfg     | cfg_write, cfg_index, cfg_data | one register write
//
// One segment per cycle while out is not stalled, through the two chains of
// one-bit divider cells, clip then projection.
// Reset clears all valid flags and loads the register defaults.
// A stall on out while out_valid is high freezes the whole pipeline and stalls in.
// Segments with both ends behind the near plane produce no word.
module line_near_clip_project (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  lncp_pkg::seg_in_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output lncp_pkg::seg_out_t out_data,
	input  logic               cfg_write,
	input  lncp_pkg::cfg_reg_t cfg_index,
	input  logic [lncp_pkg::CFG_W-1:0] cfg_data
);
	import lncp_pkg::*;

	localparam int SUM_W  = QUO_W + 3;
	localparam int SIDE_W = $bits(clip_side_t);
	localparam logic signed [SUM_W-1:0] SatHi =
		{{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SatLo = ~SatHi;

	logic [DEPTH_W-1:0] near_q, focal_q;
	logic signed [CFG_W-1:0] cx_q, cy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q  <= DEPTH_W'(65536);
			focal_q <= DEPTH_W'(16777216);
			cx_q    <= CFG_W'(10485760);
			cy_q    <= CFG_W'(6553600);
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_NEAR_DEPTH:   near_q  <= cfg_data[DEPTH_W-1:0];
				CFG_FOCAL_LENGTH: focal_q <= cfg_data[DEPTH_W-1:0];
				CFG_CENTER_X:     cx_q    <= cfg_data;
				CFG_CENTER_Y:     cy_q    <= cfg_data;
			endcase
		end
	end

	logic en;
	logic out_valid_q;
	assign en        = !out_valid_q || !out_stall;
	assign in_stall  = !en;
	assign out_valid = out_valid_q;

	// clip operands
	logic [DEPTH_W-1:0]      nz;
	logic signed [SGN_W-1:0] nzs, szs, ezs;
	logic                    cs, ce;
	logic signed [SGN_W-1:0] nx, ny, nzz, fx, fy, fz;
	logic                    v_s1;
	logic signed [SGN_W-1:0] ca_s1 [2];
	logic signed [SGN_W-1:0] cb_s1 [2];
	logic signed [SGN_W-1:0] cd_s1 [2];
	clip_side_t              side_s1;

	always_comb begin
		nz  = (near_q == '0) ? DEPTH_W'(1) : near_q;
		nzs = signed'(SGN_W'(nz));
		szs = SGN_W'(in_data.start_z);
		ezs = SGN_W'(in_data.end_z);
		cs  = szs < nzs;
		ce  = ezs < nzs;
		if (cs) begin
			nx = SGN_W'(in_data.start_x); ny = SGN_W'(in_data.start_y); nzz = szs;
			fx = SGN_W'(in_data.end_x);   fy = SGN_W'(in_data.end_y);   fz  = ezs;
		end else begin
			nx = SGN_W'(in_data.end_x);   ny = SGN_W'(in_data.end_y);   nzz = ezs;
			fx = SGN_W'(in_data.start_x); fy = SGN_W'(in_data.start_y); fz  = szs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ca_s1[0] <= nx - fx;
			ca_s1[1] <= ny - fy;
			cb_s1[0] <= nzs - fz;
			cb_s1[1] <= nzs - fz;
			cd_s1[0] <= nzz - fz;
			cd_s1[1] <= nzz - fz;
			side_s1.seg        <= in_data;
			side_s1.clip_start <= cs;
			side_s1.clip_end   <= ce;
			side_s1.near       <= nz;
		end
	end

	logic                    cv;
	logic signed [QUO_W:0]   cq [2];
	logic [SIDE_W-1:0]       cside_raw;
	clip_side_t              cside;

	lncp_muldiv #(.LANES(2), .SIDE_W(SIDE_W)) u_clip (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (v_s1),
		.a_i     (ca_s1),
		.b_i     (cb_s1),
		.d_i     (cd_s1),
		.side_i  (side_s1),
		.valid_o (cv),
		.q_o     (cq),
		.side_o  (cside_raw)
	);

	assign cside = clip_side_t'(cside_raw);

	// clipped endpoints
	logic signed [SGN_W-1:0] psx, psy, psz, pex, pey, pez;

	always_comb begin
		psx = SGN_W'(cside.seg.start_x);
		psy = SGN_W'(cside.seg.start_y);
		psz = SGN_W'(cside.seg.start_z);
		pex = SGN_W'(cside.seg.end_x);
		pey = SGN_W'(cside.seg.end_y);
		pez = SGN_W'(cside.seg.end_z);
		if (cside.clip_start) begin
			psx = pex + SGN_W'(cq[0]);
			psy = pey + SGN_W'(cq[1]);
			psz = signed'(SGN_W'(cside.near));
		end else if (cside.clip_end) begin
			pex = psx + SGN_W'(cq[0]);
			pey = psy + SGN_W'(cq[1]);
			pez = signed'(SGN_W'(cside.near));
		end
	end

	logic                    v_s2;
	logic signed [SGN_W-1:0] pa_s2 [4];
	logic signed [SGN_W-1:0] pb_s2 [4];
	logic signed [SGN_W-1:0] pd_s2 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= cv && !(cside.clip_start && cside.clip_end);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s2[0] <= psx; pa_s2[1] <= psy; pa_s2[2] <= pex; pa_s2[3] <= pey;
			pd_s2[0] <= psz; pd_s2[1] <= psz; pd_s2[2] <= pez; pd_s2[3] <= pez;
			for (int l = 0; l < 4; l++) pb_s2[l] <= signed'(SGN_W'(focal_q));
		end
	end

	logic                  pv;
	logic signed [QUO_W:0] pq [4];

	lncp_muldiv #(.LANES(4), .SIDE_W(1)) u_proj (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (v_s2),
		.a_i     (pa_s2),
		.b_i     (pb_s2),
		.d_i     (pd_s2),
		.side_i  (1'b0),
		.valid_o (pv),
		.q_o     (pq),
		.side_o  ()
	);

	function automatic logic signed [COORD_W-1:0] sat(input logic signed [SUM_W-1:0] v);
		if (v > SatHi) return COORD_W'(SatHi);
		if (v < SatLo) return COORD_W'(SatLo);
		return COORD_W'(v);
	endfunction

	seg_out_t out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= pv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q.screen_start_x <= sat(SUM_W'(cx_q) + SUM_W'(pq[0]));
			out_data_q.screen_start_y <= sat(SUM_W'(cy_q) - SUM_W'(pq[1]));
			out_data_q.screen_end_x   <= sat(SUM_W'(cx_q) + SUM_W'(pq[2]));
			out_data_q.screen_end_y   <= sat(SUM_W'(cy_q) - SUM_W'(pq[3]));
		end
	end

	assign out_data = out_data_q;

endmodule
